/* design/orl_pkg.sv */
// Shared types, constants and codes for the ordered record list.
package orl_pkg;

    // Default storage shape
    localparam int ORL_CAPACITY  = 64;
    localparam int ORL_ID_BITS   = 32;
    localparam int ORL_NAME_BITS = 64;
    localparam int ORL_DATA_BITS = 32;

    // Fixed port field widths
    localparam int REQ_W  = 3;
    localparam int POS_W  = 7;
    localparam int ID_W   = 32;
    localparam int NAME_W = 64;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_MODIFY = 3'd3,
        OP_CLEAR  = 3'd4
    } t_orl_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_FULL      = 2'd3
    } t_orl_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_WRITE,
        S_DONE
    } t_orl_state;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [ID_W-1:0]   id_key;
        logic [NAME_W-1:0] name_key;
        logic [ID_W-1:0]   new_id;
        logic [DATA_W-1:0] entry_data;
    } t_orl_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   found_id;
        logic [NAME_W-1:0] found_name;
        logic [DATA_W-1:0] found_data;
        logic [LEN_W-1:0]  list_length;
        logic              list_empty;
    } t_orl_out;

    // Controller to datapath
    typedef struct packed {
        logic        load;
        logic        scan_start;
        logic        scan_step;
        logic        take_hit;
        logic        shift_dn;
        logic        up_start;
        logic        shift_up;
        logic        wr_new;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        cnt_clr;
        logic        set_status;
        t_orl_status status;
        logic        res_load;
    } t_orl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] op;
        logic             cnt_zero;
        logic             pos_bad;
        logic             full;
        logic             slot_at_end;
        logic             hit;
        logic             scan_end;
        logic             rd_last;
        logic             up_last;
        logic             out_free;
    } t_orl_stat;

endpackage

/* design/orl_ctrl.sv */
// Request sequencer: decodes a request and steps the datapath through scan, shift and write.
module orl_ctrl
    import orl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_orl_stat i_stat,
    output t_orl_cmd  o_cmd
);

    t_orl_state r_state;
    t_orl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_LOOKUP, OP_DELETE, OP_MODIFY: begin
                        n_state = i_stat.cnt_zero ? S_DONE : S_SCAN;
                    end
                    OP_INSERT: begin
                        if (i_stat.pos_bad || i_stat.full) begin
                            n_state = S_DONE;
                        end else if (i_stat.slot_at_end) begin
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_SHIFT_UP;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    case (i_stat.op)
                        OP_MODIFY: n_state = S_WRITE;
                        OP_DELETE: n_state = i_stat.rd_last ? S_DONE : S_SHIFT_DN;
                        default:   n_state = S_DONE;
                    endcase
                end else if (i_stat.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT_DN: begin
                if (i_stat.rd_last) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT_UP: begin
                if (i_stat.up_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        o_in_stall   = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_LOOKUP, OP_DELETE, OP_MODIFY: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOT_FOUND;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BAD_POS;
                        end else if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else if (!i_stat.slot_at_end) begin
                            o_cmd.up_start = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.cnt_clr    = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_OK;
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOT_FOUND;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.take_hit   = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    // delete of the last record needs no shift
                    if (i_stat.op == OP_DELETE && i_stat.rd_last) begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                end else if (i_stat.scan_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_FOUND;
                end
            end
            S_SHIFT_DN: begin
                o_cmd.shift_dn = 1'b1;
                o_cmd.cnt_dec  = i_stat.rd_last;
            end
            S_SHIFT_UP: begin
                o_cmd.shift_up = 1'b1;
            end
            S_WRITE: begin
                o_cmd.wr_new     = 1'b1;
                o_cmd.cnt_inc    = (i_stat.op == OP_INSERT);
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_OK;
            end
            S_DONE: begin
                o_cmd.res_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

/* design/orl_dpath.sv */
// Record memory, count, walk pointer, compare and result register.
module orl_dpath
    import orl_pkg::*;
#(
    parameter int CAPACITY  = ORL_CAPACITY,
    parameter int ID_BITS   = ORL_ID_BITS,
    parameter int NAME_BITS = ORL_NAME_BITS,
    parameter int DATA_BITS = ORL_DATA_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_orl_in   i_in,
    input  t_orl_cmd  i_cmd,
    output t_orl_stat o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_orl_out  o_out
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CW1   = CW + 1;
    localparam int PW    = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int REC_W = ID_BITS + NAME_BITS + DATA_BITS;
    localparam int ID_LO = NAME_BITS + DATA_BITS;

    logic [REC_W-1:0] r_mem [CAPACITY];
    logic [REC_W-1:0] r_rdata;
    logic [REC_W-1:0] r_found;
    logic [AW-1:0]    r_raddr;
    logic [AW-1:0]    r_hit;
    logic             r_rv;
    logic [CW-1:0]    r_ptr;
    logic [CW-1:0]    r_count;
    t_orl_in          r_req;
    t_orl_status      r_status;
    t_orl_out         r_out;
    logic             r_out_valid;

    logic [CW-1:0]        slot;
    logic [ID_BITS-1:0]   key_id;
    logic [NAME_BITS-1:0] key_name;
    logic [ID_BITS-1:0]   rd_id;
    logic [NAME_BITS-1:0] rd_name;
    logic                 match;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [REC_W-1:0]     wr_data;
    logic [REC_W-1:0]     new_rec;

    assign slot     = CW'(r_req.position - POS_W'(1));
    assign key_id   = ID_BITS'(r_req.id_key);
    assign key_name = NAME_BITS'(r_req.name_key);
    assign rd_id    = r_rdata[REC_W-1 -: ID_BITS];
    assign rd_name  = r_rdata[ID_LO-1 -: NAME_BITS];
    assign match    = (r_req.req_type == OP_LOOKUP) ? (rd_name == key_name)
                                                    : (rd_id == key_id);

    // Read port: walk up for scan and close-gap, down for open-gap
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(r_ptr);
        if (i_cmd.scan_step || i_cmd.shift_dn) begin
            rd_en = (r_ptr < r_count);
        end else if (i_cmd.shift_up) begin
            rd_en   = (r_ptr > slot);
            rd_addr = AW'(r_ptr - CW'(1));
        end
    end

    always_comb begin
        if (r_req.req_type == OP_INSERT) begin
            new_rec = {ID_BITS'(r_req.id_key), key_name, DATA_BITS'(r_req.entry_data)};
        end else begin
            new_rec = {ID_BITS'(r_req.new_id), key_name, DATA_BITS'(r_req.entry_data)};
        end
    end

    // Write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_raddr;
        wr_data = r_rdata;
        if (i_cmd.shift_dn) begin
            wr_en   = r_rv;
            wr_addr = r_raddr - AW'(1);
        end else if (i_cmd.shift_up) begin
            wr_en   = r_rv;
            wr_addr = r_raddr + AW'(1);
        end else if (i_cmd.wr_new) begin
            wr_en   = 1'b1;
            wr_addr = (r_req.req_type == OP_INSERT) ? AW'(slot) : r_hit;
            wr_data = new_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_raddr <= rd_addr;
        if (i_cmd.load) begin
            r_req <= i_in;
        end
        if (i_cmd.load) begin
            r_found <= '0;
        end else if (i_cmd.take_hit && r_req.req_type == OP_LOOKUP) begin
            r_found <= r_rdata;
        end
        if (i_cmd.take_hit) begin
            r_hit <= r_raddr;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.scan_start) begin
            r_ptr <= '0;
        end else if (i_cmd.up_start) begin
            r_ptr <= r_count;
        end else if (rd_en && i_cmd.shift_up) begin
            r_ptr <= r_ptr - CW'(1);
        end else if (rd_en) begin
            r_ptr <= r_ptr + CW'(1);
        end
        if (i_cmd.res_load) begin
            r_out.status      <= r_status;
            r_out.found_id    <= ID_W'(r_found[REC_W-1 -: ID_BITS]);
            r_out.found_name  <= NAME_W'(r_found[ID_LO-1 -: NAME_BITS]);
            r_out.found_data  <= DATA_W'(r_found[DATA_BITS-1:0]);
            r_out.list_length <= LEN_W'(r_count);
            r_out.list_empty  <= (r_count == '0);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv        <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rv <= rd_en;
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.op          = r_req.req_type;
        o_stat.cnt_zero    = (r_count == '0);
        o_stat.pos_bad     = (r_req.position == '0)
                          || (PW'(r_req.position) > PW'(r_count) + PW'(1));
        o_stat.full        = (r_count == CW'(CAPACITY));
        o_stat.slot_at_end = (slot == r_count);
        o_stat.hit         = r_rv && match;
        o_stat.rd_last     = r_rv && (CW1'(r_raddr) + CW1'(1) == CW1'(r_count));
        o_stat.scan_end    = r_rv && !match && o_stat.rd_last;
        o_stat.up_last     = r_rv && (CW'(r_raddr) == slot);
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* design/ordered_record_list.sv */
// Ordered record list: bounded list with lookup, insert, delete, modify and clear.
//
// Input channel i_in / i_in_valid / o_in_stall carries one request word; output
// channel o_out / o_out_valid / i_out_stall returns exactly one result word per
// request. A word moves on a clock edge where valid is high and stall is low.
// One request is worked at a time: o_in_stall rises the cycle after a request
// is taken and falls once its result is loaded into the output register.
// Records live in a single-port-read, single-port-write memory and are walked
// one entry per cycle, so that port sets the latency. The steps after accept:
//   lookup        : decode, scan to the match (the whole list when none matches)
//   modify        : decode, scan to the match, then write (whole list when none matches)
//   delete        : decode, then search, then close the gap
//   insert        : decode, open the gap, then write; at the end, write directly
//   clear, rejects: settled at decode, as for any search of an empty list
// A new request is taken the cycle after the previous result is loaded.
// A result waiting in the output register is held while i_out_stall is high;
// a finished request waits for it.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// result; record memory contents are not cleared and need no clearing pass.
module ordered_record_list
    import orl_pkg::*;
#(
    parameter int CAPACITY  = ORL_CAPACITY,
    parameter int ID_BITS   = ORL_ID_BITS,
    parameter int NAME_BITS = ORL_NAME_BITS,
    parameter int DATA_BITS = ORL_DATA_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_orl_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_orl_out o_out
);

    t_orl_cmd  dp_cmd;
    t_orl_stat dp_stat;

    orl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    orl_dpath #(
        .CAPACITY  (CAPACITY),
        .ID_BITS   (ID_BITS),
        .NAME_BITS (NAME_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // a taken request closes the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a request was in flight");

    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.wr_new, dp_cmd.shift_up, dp_cmd.shift_dn}))
        else $error("record memory write port driven twice");

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load |-> !o_in_stall)
        else $error("request captured while busy");
`endif

endmodule
